FILE: rtl/pcpa_pkg.sv
`default_nettype none

package pcpa_pkg;

  localparam int DEF_NUM_CPUS   = 8;
  localparam int DEF_NUM_PAGES  = 32768;
  localparam int DEF_PAGE_BYTES = 4096;

  localparam int REQ_CPU_W   = 3;
  localparam int ADDR_W      = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_AW      = 1;
  localparam int CFG_DW      = 32;

  localparam logic [CFG_DW-1:0] POOL_START_RST = 32'h8000_0000;
  localparam logic [CFG_DW-1:0] POOL_STOP_RST  = 32'h8800_0000;

  localparam logic [CFG_AW-1:0] CFG_POOL_START = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_POOL_STOP  = 1'b1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_FREED   = 2'd1,
    ST_OOM     = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_LOOK,
    S_POP,
    S_SCAN,
    S_VMETA,
    S_WALK,
    S_STEAL
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/per_cpu_page_allocator_with_steal_core.sv
// Free: accept, then address check and push. No request is taken until the last result is loaded.
// Allocate from own list: head read, then link read of the popped page.
// Steal: empty CPUs are skipped and the victim's head is read; the link memory port walks
// one page per cycle over ceil(n/2) pages, n the victim's length.
// Reset (synchronous, active low) empties every list and loads the pool bounds' reset
// values; the link memory is not cleared and no clearing pass runs.
`default_nettype none

module per_cpu_page_allocator_with_steal_core import pcpa_pkg::*; #(
  parameter int NUM_CPUS   = DEF_NUM_CPUS,
  parameter int NUM_PAGES  = DEF_NUM_PAGES,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // requesting_cpu, free_addr
  input  wire logic                   in_tuser,   // opcode
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // page_addr, stole
  output logic      [1:0]             out_tuser,  // status
  input  wire logic                   cfg_we,
  input  wire logic [CFG_AW-1:0]      cfg_addr,
  input  wire logic [CFG_DW-1:0]      cfg_wdata
);

  localparam int PW = $clog2(NUM_PAGES);

  logic [ADDR_W-1:0] pool_start_r, pool_stop_r;
  logic [ADDR_W-1:0] xl_addr, xl_page_addr, out_addr;
  logic [PW-1:0]     xl_page, free_page;
  logic              free_ok, out_stole;
  status_t           out_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_start_r <= POOL_START_RST;
      pool_stop_r  <= POOL_STOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_POOL_START: pool_start_r <= cfg_wdata;
        CFG_POOL_STOP:  pool_stop_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pcpa_xlate #(.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)) u_xlate (
    .pool_start (pool_start_r),
    .pool_stop  (pool_stop_r),
    .free_addr  (xl_addr),
    .page       (xl_page),
    .free_ok    (free_ok),
    .free_page  (free_page),
    .page_addr  (xl_page_addr)
  );

  pcpa_ctrl #(.NUM_CPUS(NUM_CPUS), .NUM_PAGES(NUM_PAGES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (op_t'(in_tuser)),
    .in_cpu       (in_tdata[REQ_CPU_W-1:0]),
    .in_addr      (in_tdata[REQ_CPU_W+ADDR_W-1:REQ_CPU_W]),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_status   (out_status),
    .out_addr     (out_addr),
    .out_stole    (out_stole),
    .xl_addr      (xl_addr),
    .xl_page      (xl_page),
    .free_ok      (free_ok),
    .free_page    (free_page),
    .xl_page_addr (xl_page_addr)
  );

  assign out_tdata = {{(OUT_TDATA_W-ADDR_W-1){1'b0}}, out_stole, out_addr};
  assign out_tuser = out_status;

endmodule

`default_nettype wire

FILE: rtl/pcpa_ram.sv
`default_nettype none

module pcpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pcpa_xlate.sv
`default_nettype none

module pcpa_xlate import pcpa_pkg::*; #(
  parameter int NUM_PAGES  = DEF_NUM_PAGES,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  localparam int PW = $clog2(NUM_PAGES)
) (
  input  wire logic [ADDR_W-1:0] pool_start,
  input  wire logic [ADDR_W-1:0] pool_stop,
  input  wire logic [ADDR_W-1:0] free_addr,
  input  wire logic [PW-1:0]     page,
  output logic                   free_ok,
  output logic      [PW-1:0]     free_page,
  output logic      [ADDR_W-1:0] page_addr
);

  localparam int LPB = $clog2(PAGE_BYTES);
  localparam int NW  = ADDR_W - LPB;

  logic [NW:0] base_pn;
  logic [NW:0] diff;
  logic [32:0] diff_w;
  logic [32:0] addr_sum;
  logic [32:0] addr_sh;
  logic        aligned;
  logic        above;
  logic        below;

  // Page number of the pool base: pool_start rounded up to a whole page.
  assign base_pn = {1'b0, pool_start[ADDR_W-1:LPB]} + (NW+1)'(|pool_start[LPB-1:0]);

  assign aligned = (free_addr[LPB-1:0] == '0);
  assign above   = (free_addr >= pool_start);
  assign below   = (free_addr < pool_stop);

  // An aligned address at or above pool_start is never below the rounded base.
  assign diff    = {1'b0, free_addr[ADDR_W-1:LPB]} - base_pn;
  assign diff_w  = 33'(diff);
  assign free_ok = aligned && above && below && (diff_w < 33'(NUM_PAGES));
  assign free_page = diff_w[PW-1:0];

  assign addr_sum  = 33'(base_pn) + 33'(page);
  assign addr_sh   = addr_sum << LPB;
  assign page_addr = addr_sh[ADDR_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/pcpa_ctrl.sv
`default_nettype none

module pcpa_ctrl import pcpa_pkg::*; #(
  parameter int NUM_CPUS  = DEF_NUM_CPUS,
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  localparam int PW = $clog2(NUM_PAGES)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire op_t                  in_op,
  input  wire logic [REQ_CPU_W-1:0] in_cpu,
  input  wire logic [ADDR_W-1:0]    in_addr,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output status_t                   out_status,
  output logic      [ADDR_W-1:0]    out_addr,
  output logic                      out_stole,
  output logic      [ADDR_W-1:0]    xl_addr,
  output logic      [PW-1:0]        xl_page,
  input  wire logic                 free_ok,
  input  wire logic [PW-1:0]        free_page,
  input  wire logic [ADDR_W-1:0]    xl_page_addr
);

  localparam int CPUW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CNTW = $clog2(NUM_PAGES + 1);
  localparam int MW   = PW + CNTW;
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(NUM_PAGES);
  localparam logic [CNTW-1:0] CNT_ONE  = CNTW'(1);
  localparam logic [CPUW-1:0] CPU_LAST = CPUW'(NUM_CPUS - 1);

  state_t state_r, state_nxt;

  logic [CPUW-1:0]     cpu_r, cpu_in, cpu_next;
  logic [CPUW-1:0]     scan_r, scan_next, victim_r, left_r;
  logic [3:0]          cpu_m;
  logic [ADDR_W-1:0]   addr_r;
  logic [NUM_CPUS-1:0] nonempty_r;
  logic [PW-1:0]       vhead_r, req_head_r;
  logic [CNTW-1:0]     take_r, vrest_r, rem_r;
  logic                first_r;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic                out_stole_r;

  logic                meta_re, meta_we;
  logic [CPUW-1:0]     meta_ra, meta_wa;
  logic [MW-1:0]       meta_rd, meta_wd;
  logic                link_re, link_we;
  logic [PW-1:0]       link_ra, link_wa, link_wd, link_rd;

  logic                accept, out_free, meta_v, rem_last, load_out;
  logic [PW-1:0]       m_head, own_head;
  logic [CNTW-1:0]     m_cnt, own_cnt, take;
  logic [CNTW:0]       take_sum;
  status_t             res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic                res_stole;

  // Per-CPU head and length; a CPU whose nonempty bit is clear reads as an empty list.
  pcpa_ram #(.WIDTH(MW), .DEPTH(NUM_CPUS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_wa),
    .wdata (meta_wd),
    .re    (meta_re),
    .raddr (meta_ra),
    .rdata (meta_rd)
  );

  // Next-page links of all listed pages.
  pcpa_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_wa),
    .wdata (link_wd),
    .re    (link_re),
    .raddr (link_ra),
    .rdata (link_rd)
  );

  // Requests from a CPU number beyond the configured count wrap around.
  always_comb begin
    cpu_m = {1'b0, in_cpu};
    for (int i = 0; i < 8; i++) begin
      if (32'(cpu_m) >= NUM_CPUS) begin
        cpu_m = cpu_m - 4'(NUM_CPUS);
      end
    end
  end
  assign cpu_in = CPUW'(cpu_m);

  assign cpu_next  = (cpu_r == CPU_LAST) ? '0 : cpu_r + CPUW'(1);
  assign scan_next = (scan_r == CPU_LAST) ? '0 : scan_r + CPUW'(1);

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign meta_v   = nonempty_r[cpu_r];
  assign m_head   = meta_rd[PW-1:0];
  assign m_cnt    = meta_rd[MW-1:PW];
  assign own_head = meta_v ? m_head : '0;
  assign own_cnt  = meta_v ? m_cnt : '0;
  assign take_sum = {1'b0, m_cnt} + {{CNTW{1'b0}}, 1'b1};
  assign take     = take_sum[CNTW:1];
  assign rem_last = (rem_r == CNT_ONE);
  assign xl_addr  = addr_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == OP_FREE) ? S_FREE : S_LOOK;
        end
      end
      S_FREE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_LOOK: begin
        state_nxt = meta_v ? S_POP : S_SCAN;
      end
      S_POP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (left_r == '0) begin
          if (out_free) state_nxt = S_IDLE;
        end else if (nonempty_r[scan_r]) begin
          state_nxt = S_VMETA;
        end
      end
      S_VMETA: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (rem_last) state_nxt = S_STEAL;
      end
      S_STEAL: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory accesses and result. Reads and writes of one memory never fall on the
  // same edge: writes happen only on leaving a work state, reads only on leaving
  // IDLE, SCAN, LOOK, VMETA or a non-final WALK step.
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    meta_re    = 1'b0;
    meta_ra    = cpu_in;
    meta_we    = 1'b0;
    meta_wa    = cpu_r;
    meta_wd    = '0;
    link_re    = 1'b0;
    link_ra    = own_head;
    link_we    = 1'b0;
    link_wa    = free_page;
    link_wd    = own_head;
    load_out   = 1'b0;
    res_status = ST_FREED;
    res_addr   = '0;
    res_stole  = 1'b0;
    xl_page    = own_head;
    unique case (state_r)
      S_IDLE: begin
        meta_re = accept;
      end
      S_FREE: begin
        load_out = out_free;
        if (free_ok) begin
          res_status = ST_FREED;
          // A push onto a full list is dropped but still reported as freed.
          if (own_cnt != CNT_FULL && out_free) begin
            link_we = 1'b1;
            meta_we = 1'b1;
            meta_wd = {own_cnt + CNT_ONE, free_page};
          end
        end else begin
          res_status = ST_BADFREE;
        end
      end
      S_LOOK: begin
        link_re = meta_v;
      end
      S_POP: begin
        load_out   = out_free;
        res_status = ST_ALLOC;
        res_addr   = xl_page_addr;
        meta_we    = out_free;
        meta_wd    = {own_cnt - CNT_ONE, link_rd};
      end
      S_SCAN: begin
        if (left_r == '0) begin
          load_out   = out_free;
          res_status = ST_OOM;
        end else if (nonempty_r[scan_r]) begin
          meta_re = 1'b1;
          meta_ra = scan_r;
        end
      end
      S_VMETA: begin
        link_re = 1'b1;
        link_ra = m_head;
      end
      S_WALK: begin
        if (!rem_last) begin
          link_re = 1'b1;
          link_ra = link_rd;
        end else begin
          meta_we = 1'b1;
          meta_wa = victim_r;
          meta_wd = {vrest_r, link_rd};
        end
      end
      S_STEAL: begin
        load_out   = out_free;
        res_status = ST_ALLOC;
        res_stole  = 1'b1;
        xl_page    = vhead_r;
        res_addr   = xl_page_addr;
        meta_we    = out_free;
        meta_wd    = {take_r - CNT_ONE, req_head_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (meta_we) begin
        nonempty_r[meta_wa] <= (meta_wd[MW-1:PW] != '0);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cpu_r  <= cpu_in;
      addr_r <= in_addr;
    end
    if (state_r == S_LOOK) begin
      scan_r <= cpu_next;
      left_r <= CPU_LAST;
    end else if (state_r == S_SCAN && left_r != '0 && !nonempty_r[scan_r]) begin
      scan_r <= scan_next;
      left_r <= left_r - CPUW'(1);
    end
    if (state_r == S_SCAN) begin
      victim_r <= scan_r;
    end
    // The victim gives up the first ceil(n/2) pages; the walk reads that many links.
    if (state_r == S_VMETA) begin
      vhead_r <= m_head;
      take_r  <= take;
      rem_r   <= take;
      vrest_r <= m_cnt - take;
      first_r <= 1'b1;
    end
    if (state_r == S_WALK) begin
      first_r <= 1'b0;
      rem_r   <= rem_r - CNT_ONE;
      if (first_r) begin
        req_head_r <= link_rd;
      end
    end
    if (load_out) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_stole_r  <= res_stole;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_addr   = out_addr_r;
  assign out_stole  = out_stole_r;

  a_meta_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(meta_we && meta_re))
    else $error("meta memory read and written on the same edge");

  a_link_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(link_we && link_re))
    else $error("link memory read and written on the same edge");

  a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> rem_r != '0)
    else $error("steal walk ran past its length");

  a_victim_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_VMETA |-> m_cnt != '0)
    else $error("victim marked nonempty holds an empty list");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result lost on load");

endmodule

`default_nettype wire
